FILE: sv/dnx_pkg.sv
`default_nettype none

package dnx_pkg;

  localparam int unsigned POS_W                 = 7;
  localparam logic [POS_W-1:0] POS_MAX          = 7'd127;
  localparam int unsigned IP6_HDR_BYTES         = 40;
  localparam int unsigned UDP_HDR_BYTES         = 8;
  localparam int unsigned DNS_HEADER_BYTES      = 12;
  localparam int unsigned LINK_HEADER_BYTES_DEF = 14;

  localparam logic [15:0] DNS_PORT_RST = 16'd53;
  localparam logic [7:0]  PTR_MIN      = 8'hC0;
  localparam logic [7:0]  CHAR_DOT     = 8'h2E;
  localparam logic [7:0]  CHAR_NL      = 8'h0A;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_LABEL,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_word_t;

  typedef struct packed {
    logic [7:0] name_char;
    logic       name_done;
  } name_word_t;

endpackage

`default_nettype wire

FILE: sv/dnx_frame_if.sv
`default_nettype none

interface dnx_frame_if;
  import dnx_pkg::*;

  logic        valid;
  logic        ready;
  frame_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/dnx_name_if.sv
`default_nettype none

interface dnx_name_if;
  import dnx_pkg::*;

  logic       valid;
  logic       ready;
  name_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/dns_response_name_extractor.sv
// DNS response name extractor.
// frame_i takes one raw frame word per cycle while ready (byte plus end-of-frame
// flag); the Ethernet/IPv6/UDP layout is fixed, with the DNS message after the
// link header, IPv6 and UDP headers. Frames whose UDP destination port
// equals the configured port (cfg_we_i / cfg_data_i, reset 53) and whose
// DNS QR bit is set have their first question name streamed on name_o:
// label characters, '.' between labels, and a newline word with name_done
// set at the terminator or a compression pointer.
// Each accepted byte is decoded in the cycle it is taken and its results
// are registered in a 4-entry output queue that feeds name_o. Throughput is
// one byte per cycle while frame_i.ready is high; name_o drains one word
// per cycle while name_o.ready is high. A byte can yield two words (pointer
// after a label), so frame_i.ready drops while the queue holds more than two
// words, which also carries any stall from the receiver back to the source.
// Reset (rst_ni low) clears the frame state, empties the queue and restores
// the port register to 53. frame_end returns the frame state to its reset
// values after that byte is decoded.
`default_nettype none

module dns_response_name_extractor #(
  parameter int unsigned LINK_HEADER_BYTES = dnx_pkg::LINK_HEADER_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  dnx_frame_if.sink        frame_i,
  dnx_name_if.source       name_o
);
  import dnx_pkg::*;

  localparam int unsigned DNS_START = LINK_HEADER_BYTES + IP6_HDR_BYTES + UDP_HDR_BYTES;
  localparam logic [POS_W-1:0] DPORT_HI_POS =
    POS_W'(LINK_HEADER_BYTES + IP6_HDR_BYTES + 2);
  localparam logic [POS_W-1:0] DPORT_LO_POS =
    POS_W'(LINK_HEADER_BYTES + IP6_HDR_BYTES + 3);
  localparam logic [POS_W-1:0] FLAGS_POS = POS_W'(DNS_START + 2);
  localparam logic [POS_W-1:0] NAME_POS  = POS_W'(DNS_START + DNS_HEADER_BYTES);

  logic [15:0]      dns_port_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       port_hi_q, port_hi_d;
  logic             match_q, match_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       left_q, left_d;
  logic             first_q, first_d;

  name_word_t       mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  logic       accept, pop, do_len;
  logic       push_dot, push_nl, push_chr;
  logic [1:0] n_push;
  logic [7:0] b;
  name_word_t r0, r1;

  assign accept = frame_i.valid && frame_i.ready;
  assign pop    = name_o.valid && name_o.ready;
  assign b      = frame_i.data.frame_byte;

  assign frame_i.ready = cnt_q <= CNT_W'(FIFO_DEPTH - 2);
  assign name_o.valid  = cnt_q != '0;
  assign name_o.data   = mem_q[rd_q];

  always_comb begin
    pos_d     = pos_q;
    port_hi_d = port_hi_q;
    match_d   = match_q;
    phase_d   = phase_q;
    left_d    = left_q;
    first_d   = first_q;
    do_len    = 1'b0;
    push_dot  = 1'b0;
    push_nl   = 1'b0;
    push_chr  = 1'b0;
    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          if (pos_q == DPORT_HI_POS) port_hi_d = b;
          if (pos_q == DPORT_LO_POS && {port_hi_q, b} != dns_port_q) match_d = 1'b0;
          if (pos_q == FLAGS_POS && !b[7]) match_d = 1'b0;
          if (pos_q == NAME_POS) begin
            if (match_q) do_len = 1'b1;
            else phase_d = PH_DONE;
          end
          if (pos_q != POS_MAX) pos_d = pos_q + POS_W'(1);
        end
        PH_LENGTH: do_len = 1'b1;
        PH_LABEL: begin
          push_chr = 1'b1;
          if (left_q != '0) left_d = left_q - 8'd1;
          if (left_q <= 8'd1) begin
            first_d = 1'b0;
            phase_d = PH_LENGTH;
          end
        end
        default: ;
      endcase
      if (do_len) begin
        if (b == '0) begin
          push_nl = 1'b1;
          phase_d = PH_DONE;
        end else begin
          push_dot = !first_q;
          if (b >= PTR_MIN) begin
            push_nl = 1'b1;
            phase_d = PH_DONE;
          end else begin
            left_d  = b;
            phase_d = PH_LABEL;
          end
        end
      end
      if (frame_i.data.frame_end) begin
        pos_d     = '0;
        port_hi_d = '0;
        match_d   = 1'b1;
        phase_d   = PH_HEADER;
        left_d    = '0;
        first_d   = 1'b1;
      end
    end
  end

  always_comb begin
    n_push = 2'(push_dot) + 2'(push_nl) + 2'(push_chr);
    r0.name_char = push_dot ? CHAR_DOT : (push_nl ? CHAR_NL : b);
    r0.name_done = !push_dot && push_nl;
    r1.name_char = CHAR_NL;
    r1.name_done = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dns_port_q <= DNS_PORT_RST;
      pos_q      <= '0;
      port_hi_q  <= '0;
      match_q    <= 1'b1;
      phase_q    <= PH_HEADER;
      left_q     <= '0;
      first_q    <= 1'b1;
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) dns_port_q <= cfg_data_i;
      pos_q     <= pos_d;
      port_hi_q <= port_hi_d;
      match_q   <= match_d;
      phase_q   <= phase_d;
      left_q    <= left_d;
      first_q   <= first_d;
      wr_q      <= wr_q + PTR_W'(n_push);
      rd_q      <= rd_q + PTR_W'(pop);
      cnt_q     <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_q] <= r0;
    if (n_push == 2'd2) mem_q[wr_q + PTR_W'(1)] <= r1;
  end

  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  // two words from one byte are always separator then closing newline
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_push == 2'd2 |-> push_dot && push_nl && !push_chr)
    else $error("bad word pair");

  // a label in progress always has characters left
  a_label_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LABEL |-> left_q != '0)
    else $error("empty label in progress");

  // closing newline ends the name unless the frame ended on it
  a_done_after_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_nl && !frame_i.data.frame_end |=> phase_q == PH_DONE)
    else $error("name not closed after newline");

  // no words emitted before the name offset is reached
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER && pos_q != NAME_POS |-> n_push == 2'd0)
    else $error("word emitted in header");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
  import dnx_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned PORT_HI_AT  = LINK_HEADER_BYTES_DEF + IP6_HDR_BYTES + 2;
  localparam int unsigned PORT_LO_AT  = PORT_HI_AT + 1;
  localparam int unsigned DNS_AT      = LINK_HEADER_BYTES_DEF + IP6_HDR_BYTES + UDP_HDR_BYTES;
  localparam int unsigned FLAGS_AT    = DNS_AT + 2;
  localparam int unsigned NAME_AT     = DNS_AT + DNS_HEADER_BYTES;
  localparam logic [7:0]  QR_BIT      = 8'h80;
  localparam logic [7:0]  ROOT_LEN    = 8'h00;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_BYTES = 20;

  class name_scoreboard;
    logic [15:0]      port;
    logic [POS_W-1:0] pos;
    logic [7:0]       port_hi;
    bit               frame_ok;
    phase_e           phase;
    logic [7:0]       bytes_left;
    bit               first;
    name_word_t       expected_q[$];
    int               errors;
    int               checked;
    int               names;

    function new();
      port    = DNS_PORT_RST;
      errors  = 0;
      checked = 0;
      names   = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      pos        = '0;
      port_hi    = '0;
      frame_ok   = 1'b1;
      phase      = PH_HEADER;
      bytes_left = '0;
      first      = 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push(logic [7:0] c, logic d);
      name_word_t w;
      w.name_char = c;
      w.name_done = d;
      expected_q.push_back(w);
    endfunction

    function void take_length(logic [7:0] b);
      if (b == ROOT_LEN) begin
        phase = PH_DONE;
        push(CHAR_NL, 1'b1);
      end else begin
        if (!first) push(CHAR_DOT, 1'b0);
        if (b >= PTR_MIN) begin
          phase = PH_DONE;
          push(CHAR_NL, 1'b1);
        end else begin
          bytes_left = b;
          phase      = PH_LABEL;
        end
      end
    endfunction

    function void note_frame_word(frame_word_t w);
      case (phase)
        PH_HEADER: begin
          if (pos == PORT_HI_AT) port_hi = w.frame_byte;
          if (pos == PORT_LO_AT && {port_hi, w.frame_byte} != port) frame_ok = 1'b0;
          if (pos == FLAGS_AT && (w.frame_byte & QR_BIT) == 8'd0) frame_ok = 1'b0;
          if (pos == NAME_AT) begin
            if (frame_ok) take_length(w.frame_byte);
            else phase = PH_DONE;
          end
          if (pos != POS_MAX) pos = pos + 1'b1;
        end
        PH_LENGTH: take_length(w.frame_byte);
        PH_LABEL: begin
          push(w.frame_byte, 1'b0);
          if (bytes_left != 8'd0) bytes_left = bytes_left - 1'b1;
          if (bytes_left == 8'd0) begin
            first = 1'b0;
            phase = PH_LENGTH;
          end
        end
        default: ;
      endcase
      if (w.frame_end) restart_frame();
    endfunction

    function void check_name_word(name_word_t got);
      name_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("unexpected name word: name_char %h name_done %0b",
               got.name_char, got.name_done);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.name_char !== want.name_char) begin
        errors++;
        $error("name_char: expected %h, actual %h", want.name_char, got.name_char);
      end
      if (got.name_done !== want.name_done) begin
        errors++;
        $error("name_done: expected %0b, actual %0b", want.name_done, got.name_done);
      end
      if (want.name_done) names++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;

  dnx_frame_if frame_bus ();
  dnx_name_if  name_bus ();

  dns_response_name_extractor u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .frame_i    (frame_bus),
    .name_o     (name_bus)
  );

  name_scoreboard names_sb = new();
  bit             calm = 1'b0;
  int unsigned    cycles = 0;
  int             frames_sent = 0;
  int             bytes_sent = 0;
  logic [15:0]    cur_port = DNS_PORT_RST;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1)
      names_sb.note_frame_word(frame_bus.data);
    if (name_bus.valid === 1'b1 && name_bus.ready === 1'b1)
      names_sb.check_name_word(name_bus.data);
    if (cycles > CYCLE_LIMIT) begin
      $display("dns_response_name_extractor regression: fail");
      $finish;
    end
  end

  function automatic int pick_idle();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver stalls; calm toggles stretches with no idling on either side
  initial begin
    int stall;
    stall = 0;
    name_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 299) == 0) calm = !calm;
      if (stall > 0) begin
        name_bus.ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_idle();
        if (stall == 0) begin
          name_bus.ready <= 1'b1;
        end else begin
          name_bus.ready <= 1'b0;
          stall--;
        end
      end
    end
  end

  task automatic send_word(logic [7:0] b, logic e);
    int          idle;
    frame_word_t w;
    idle = pick_idle();
    if (idle > 0) begin
      frame_bus.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    w.frame_byte = b;
    w.frame_end  = e;
    frame_bus.valid <= 1'b1;
    frame_bus.data  <= w;
    @(posedge clk_i);
    while (frame_bus.ready !== 1'b1) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_q_t f);
    foreach (f[i]) send_word(f[i], i == f.size() - 1);
    frames_sent++;
  endtask

  task automatic wait_drained();
    frame_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (names_sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_port(logic [15:0] v);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    names_sb.port = v;
    cur_port = v;
  endtask

  function automatic void make_frame(output byte_q_t f, input logic [15:0] dport,
                                     input logic qr, input byte_q_t name);
    f = {};
    for (int i = 0; i < NAME_AT; i++) f.push_back(8'($urandom_range(0, 255)));
    f[PORT_HI_AT] = dport[15:8];
    f[PORT_LO_AT] = dport[7:0];
    f[FLAGS_AT]   = {qr, f[FLAGS_AT][6:0]};
    foreach (name[i]) f.push_back(name[i]);
  endfunction

  function automatic void random_frame(output byte_q_t f);
    byte_q_t     name;
    int          labels;
    int          len;
    int          cut;
    logic [15:0] dport;
    name   = {};
    labels = $urandom_range(0, 4);
    for (int l = 0; l < labels; l++) begin
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(8'h40, 8'hBF)
                                         : $urandom_range(1, 10);
      name.push_back(8'(len));
      repeat (len) name.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 2) == 0) begin
      name.push_back(8'($urandom_range(8'hC0, 8'hFF)));
      name.push_back(8'($urandom_range(0, 255)));
    end else begin
      name.push_back(ROOT_LEN);
    end
    repeat ($urandom_range(0, 6)) name.push_back(8'($urandom_range(0, 255)));
    dport = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535)) : cur_port;
    make_frame(f, dport, $urandom_range(0, 7) != 0, name);
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, f.size());
      while (f.size() > cut) void'(f.pop_back());
    end
  endfunction

  task automatic random_frames(int unsigned count);
    byte_q_t     f;
    int unsigned target;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      random_frame(f);
      send_frame(f);
    end
  endtask

  initial begin
    byte_q_t f;
    byte_q_t name;

    frame_bus.valid <= 1'b0;
    frame_bus.data  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    name = {8'd2, 8'h61, 8'h62, 8'd1, 8'h63, ROOT_LEN, 8'h5A};
    make_frame(f, DNS_PORT_RST, 1'b1, name);
    send_frame(f);
    name = {PTR_MIN, 8'h0C};
    make_frame(f, DNS_PORT_RST, 1'b1, name);
    send_frame(f);
    // label followed by pointer: dot and newline from one word
    name = {8'd1, 8'h78, 8'hFF, 8'h00};
    make_frame(f, DNS_PORT_RST, 1'b1, name);
    send_frame(f);
    name = {ROOT_LEN};
    make_frame(f, DNS_PORT_RST, 1'b1, name);
    send_frame(f);
    name = {8'd1, 8'h71, ROOT_LEN};
    make_frame(f, DNS_PORT_RST, 1'b0, name);
    send_frame(f);
    make_frame(f, DNS_PORT_RST + 16'd1, 1'b1, name);
    send_frame(f);
    name = {8'd5, 8'h68, 8'h65};
    make_frame(f, DNS_PORT_RST, 1'b1, name);
    send_frame(f);
    f = {8'hA5};
    send_frame(f);
    name = {};
    make_frame(f, DNS_PORT_RST, 1'b1, name);
    send_frame(f);
    name = {8'h40};
    repeat (64) name.push_back(8'($urandom_range(0, 255)));
    name.push_back(ROOT_LEN);
    make_frame(f, DNS_PORT_RST, 1'b1, name);
    send_frame(f);
    name = {8'hBF};
    repeat (191) name.push_back(8'($urandom_range(0, 255)));
    name.push_back(8'd1);
    name.push_back(8'h7E);
    name.push_back(ROOT_LEN);
    make_frame(f, DNS_PORT_RST, 1'b1, name);
    send_frame(f);

    set_port(16'hFFFF);
    name = {8'd3, 8'h77, 8'h77, 8'h77, ROOT_LEN};
    make_frame(f, 16'hFFFF, 1'b1, name);
    send_frame(f);
    make_frame(f, DNS_PORT_RST, 1'b1, name);
    send_frame(f);
    random_frames(PHASE_BYTES);

    set_port(16'h0000);
    name = {8'd1, 8'h7A, PTR_MIN, 8'h20};
    make_frame(f, 16'h0000, 1'b1, name);
    send_frame(f);
    random_frames(PHASE_BYTES);

    set_port(16'($urandom_range(0, 65535)));
    random_frames(PHASE_BYTES);

    set_port(DNS_PORT_RST);
    random_frames(PHASE_BYTES);

    wait_drained();
    $display("sent %0d frames (%0d bytes) over 5 port settings", frames_sent, bytes_sent);
    $display("checked %0d name words, %0d complete names", names_sb.checked, names_sb.names);
    if (names_sb.errors == 0) begin
      $display("dns_response_name_extractor regression: pass");
    end else begin
      $display("dns_response_name_extractor regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
